@@ rtl/lidar_ttc_emergency_brake_macros.svh @@
// assertion macros used by the ttc brake back end
`ifndef LIDAR_TTC_EMERGENCY_BRAKE_MACROS_SVH
`define LIDAR_TTC_EMERGENCY_BRAKE_MACROS_SVH
`ifndef ASSERT_OFF
`define LTB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ltb: same-cycle check failed");
`define LTB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ltb: next-cycle check failed");
`else
`define LTB_ASSERT_IMPL(label, ante, cons)
`define LTB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/ltb_pkg.sv @@
// types, constants and helper functions of the ttc emergency brake
package ltb_pkg;

	localparam int MAX_SAMPLES_DEF    = 4096;
	localparam int COS_TABLE_BITS_DEF = 10;
	localparam int QUEUE_DEPTH        = 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THR_FWD     = 3'd0,
		REG_THR_BWD     = 3'd1,
		REG_RANGE_LO    = 3'd2,
		REG_RANGE_HI    = 3'd3,
		REG_ANGLE_START = 3'd4,
		REG_ANGLE_STEP  = 3'd5
	} cfg_reg_t;

	localparam logic [15:0] THR_FWD_RST     = 16'd256;
	localparam logic [15:0] THR_BWD_RST     = 16'd256;
	localparam logic [15:0] RANGE_LO_RST    = 16'd0;
	localparam logic [15:0] RANGE_HI_RST    = 16'hFFFF;
	localparam logic [15:0] ANGLE_START_RST = 16'h9B78;
	localparam logic [14:0] ANGLE_STEP_RST  = 15'd47;

	// 2^32 / (2 pi) and 2 pi * 2^28
	localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;
	localparam logic [30:0] TWO_PI_Q28     = 31'd1686629713;
	localparam logic [31:0] ONE_Q30        = 32'h4000_0000;
	localparam logic [31:0] TTC_INF        = 32'hFFFF_FFFF;
	localparam logic [31:0] TTC_MAX_FINITE = 32'hFFFF_FFFE;
	localparam logic [2:0]  HORNER_LAST    = 3'd5;

	typedef struct packed {
		logic [15:0] thr_fwd;
		logic [15:0] thr_bwd;
		logic [15:0] range_lo;
		logic [15:0] range_hi;
		logic [15:0] angle_start;
		logic [14:0] angle_step;
	} cfg_t;

	typedef enum logic [1:0] {
		KIND_SPEED,
		KIND_VALID,
		KIND_INVALID
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [15:0] speed;
		logic [15:0] range;
		logic        last;
	} qent_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	typedef enum logic [3:0] {
		BK_IDLE,
		BK_ANG,
		BK_ANG2,
		BK_PL,
		BK_PH,
		BK_X,
		BK_X2,
		BK_H1,
		BK_H2,
		BK_H3,
		BK_H4,
		BK_COS,
		BK_V,
		BK_DIV,
		BK_UPD,
		BK_OUT
	} bk_state_t;

	// horner divisors of the cosine series
	function automatic logic [7:0] horner_k(input logic [2:0] h);
		logic [7:0] k;
		unique case (h)
			3'd0:    k = 8'd132;
			3'd1:    k = 8'd90;
			3'd2:    k = 8'd56;
			3'd3:    k = 8'd30;
			3'd4:    k = 8'd12;
			default: k = 8'd2;
		endcase
		return k;
	endfunction

	// floor(2^32 / k) for the reciprocal divide
	function automatic logic [31:0] horner_recip(input logic [2:0] h);
		logic [31:0] r;
		unique case (h)
			3'd0:    r = 32'd32537631;
			3'd1:    r = 32'd47721858;
			3'd2:    r = 32'd76695844;
			3'd3:    r = 32'd143165576;
			3'd4:    r = 32'd357913941;
			default: r = 32'd2147483648;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/ltb_in_if.sv @@
// input channel: speed updates and range samples
interface ltb_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic signed [15:0] speed_value;
	logic [15:0] range_value;
	logic        last_sample;

	modport source (output valid, func, speed_value, range_value, last_sample, input ready);
	modport sink   (input valid, func, speed_value, range_value, last_sample, output ready);
endinterface

@@ rtl/ltb_out_if.sv @@
// result channel: brake flag and scan minimum ttc
interface ltb_out_if;
	logic        valid;
	logic        ready;
	logic        brake;
	logic [31:0] min_ttc;

	modport source (output valid, brake, min_ttc, input ready);
	modport sink   (input valid, brake, min_ttc, output ready);
endinterface

@@ rtl/ltb_front.sv @@
// front end: accepts input beats and classifies them for the queue
module ltb_front import ltb_pkg::*; (
	ltb_in_if.sink  in_ch,
	input  cfg_t    cfg,
	input  qstat_t  qstat,
	output logic    push,
	output qent_t   push_ent
);

	logic out_of_range;

	assign in_ch.ready  = !qstat.full;
	assign push         = in_ch.valid && !qstat.full;
	assign out_of_range = (in_ch.range_value < cfg.range_lo) ||
		(in_ch.range_value > cfg.range_hi);

	always_comb begin
		push_ent.speed = in_ch.speed_value;
		push_ent.range = in_ch.range_value;
		push_ent.last  = in_ch.last_sample;
		if (!in_ch.func) begin
			push_ent.kind = KIND_SPEED;
		end else if (out_of_range) begin
			push_ent.kind = KIND_INVALID;
		end else begin
			push_ent.kind = KIND_VALID;
		end
	end

endmodule

@@ rtl/ltb_queue.sv @@
// short fifo between front end and back end
module ltb_queue import ltb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  qent_t  push_ent,
	input  logic   pop,
	output qstat_t qstat,
	output qent_t  head
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	qent_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_q, rd_q;
	logic [CNW-1:0] cnt_q;

	assign qstat.empty = (cnt_q == '0);
	assign qstat.full  = (cnt_q == CNW'(QUEUE_DEPTH));
	assign head        = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/ltb_back.sv @@
// back end: angle, cosine, closing rate, ttc divide and scan minimum
`include "lidar_ttc_emergency_brake_macros.svh"
module ltb_back import ltb_pkg::*; #(
	parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
	parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  qstat_t qstat,
	input  qent_t  head,
	output logic   pop,
	ltb_out_if.source out_ch
);

	localparam int CW    = $clog2(MAX_SAMPLES);
	localparam int CTB   = COS_TABLE_BITS;
	localparam int SHIFT = 45 - CTB;
	localparam logic [CTB:0]  FULL    = (CTB+1)'(1) << CTB;
	localparam logic [CTB:0]  HALF    = (CTB+1)'(1) << (CTB - 1);
	localparam logic [CTB:0]  QUARTER = (CTB+1)'(1) << (CTB - 2);
	localparam logic [44:0]   ROUND   = 45'(1) << (SHIFT - 1);

	bk_state_t state_q, state_d;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod_q;
	logic        out_load;

	logic [15:0]   speed_q;
	logic          bwd_q;
	logic [31:0]   min_q;
	logic [CW-1:0] counter_q;
	logic [15:0]   range_q;
	logic          last_q;
	logic [21:0]   a_hi_q;
	logic [44:0]   plo_q;
	logic          cneg_q;
	logic [31:0]   x2_q, n_q, qe_q;
	logic signed [32:0] t_q;
	logic [2:0]    h_q;
	logic          vneg_q;
	logic [30:0]   v_q, r_q;
	logic [31:0]   quo_q;
	logic [4:0]    dcnt_q;
	logic [31:0]   ttc_q;
	logic          res_brake_q;
	logic [31:0]   res_min_q;
	logic          out_valid_q, out_brake_q;
	logic [31:0]   out_min_q;

	// combinational helpers
	logic signed [32:0] angle;
	logic [44:0]   angle45, p_sum, p_rnd;
	logic [CTB-1:0] idx;
	logic [CTB:0]  m1, m_fold;
	logic          fold_neg;
	logic [31:0]   r_fix, x_op;
	logic [32:0]   q_fix;
	logic [30:0]   t_clamp;
	logic [31:0]   c_sum;
	logic [15:0]   c_mag, spd_mag;
	logic [30:0]   v_now;
	logic          ttc_sat;
	logic [31:0]   r2;
	logic          div_bit;
	logic [31:0]   quo_next, ttc_div;
	logic [31:0]   min_new, thr32;

	assign angle = $signed({{17{cfg.angle_start[15]}}, cfg.angle_start}) +
		$signed({2'b00, prod_q[30:0]});
	assign angle45 = {{12{angle[32]}}, angle};

	assign p_sum = plo_q + {prod_q[21:0], 23'd0};
	assign p_rnd = p_sum + ROUND;
	assign idx   = p_rnd[44:SHIFT];

	// fold the table index into the first quadrant
	always_comb begin
		m1 = (idx > HALF[CTB-1:0] && !HALF[CTB]) || ({1'b0, idx} > HALF) ?
			FULL - {1'b0, idx} : {1'b0, idx};
		fold_neg = m1 > QUARTER;
		m_fold   = fold_neg ? HALF - m1 : m1;
	end

	assign x_op    = prod_q[CTB-2 +: 32];
	assign r_fix   = n_q - prod_q[31:0];
	assign q_fix   = {1'b0, qe_q} + ((r_fix >= {24'd0, horner_k(h_q)}) ? 33'd1 : 33'd0);
	assign t_clamp = t_q[32] ? 31'd0 : t_q[30:0];
	assign c_sum   = {1'b0, t_clamp} + 32'd16384;
	assign c_mag   = c_sum[30:15];
	assign spd_mag = speed_q[15] ? (~speed_q + 16'd1) : speed_q;

	assign v_now   = prod_q[30:0];
	assign ttc_sat = {16'd0, range_q} >= {v_now, 1'b0};

	assign r2       = {r_q, (dcnt_q == 5'd0) ? range_q[0] : 1'b0};
	assign div_bit  = r2 >= {1'b0, v_q};
	assign quo_next = {quo_q[30:0], div_bit};
	assign ttc_div  = (quo_next == TTC_INF) ? TTC_MAX_FINITE : quo_next;

	assign min_new = (ttc_q < min_q) ? ttc_q : min_q;
	assign thr32   = {8'd0, bwd_q ? cfg.thr_bwd : cfg.thr_fwd, 8'd0};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!qstat.empty) begin
					unique case (head.kind)
						KIND_VALID:   state_d = BK_ANG;
						KIND_INVALID: state_d = BK_UPD;
						default:      state_d = BK_IDLE;
					endcase
				end
			end
			BK_ANG:  state_d = BK_ANG2;
			BK_ANG2: state_d = BK_PL;
			BK_PL:   state_d = BK_PH;
			BK_PH:   state_d = BK_X;
			BK_X:    state_d = BK_X2;
			BK_X2:   state_d = BK_H1;
			BK_H1:   state_d = BK_H2;
			BK_H2:   state_d = BK_H3;
			BK_H3:   state_d = BK_H4;
			BK_H4:   state_d = (h_q == HORNER_LAST) ? BK_COS : BK_H1;
			BK_COS:  state_d = BK_V;
			BK_V: begin
				if (v_now == '0 || vneg_q || ttc_sat) begin
					state_d = BK_UPD;
				end else begin
					state_d = BK_DIV;
				end
			end
			BK_DIV:  state_d = (dcnt_q == 5'd31) ? BK_UPD : BK_DIV;
			BK_UPD:  state_d = last_q ? BK_OUT : BK_IDLE;
			BK_OUT:  state_d = out_load ? BK_IDLE : BK_OUT;
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs: queue pop, multiplier operands, result load
	always_comb begin
		pop      = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: pop = !qstat.empty;
			BK_ANG: begin
				mul_a = {17'd0, cfg.angle_step};
				mul_b = 32'(counter_q);
			end
			BK_ANG2: begin
				mul_a = {9'd0, angle45[22:0]};
				mul_b = {2'd0, INV_TWO_PI_Q32};
			end
			BK_PL: begin
				mul_a = {10'd0, a_hi_q};
				mul_b = {2'd0, INV_TWO_PI_Q32};
			end
			BK_PH: begin
				mul_a = 32'(m_fold);
				mul_b = {1'b0, TWO_PI_Q28};
			end
			BK_X: begin
				mul_a = x_op;
				mul_b = x_op;
			end
			BK_H1: begin
				mul_a = x2_q;
				mul_b = t_q[31:0];
			end
			BK_H2: begin
				mul_a = prod_q[61:30];
				mul_b = horner_recip(h_q);
			end
			BK_H3: begin
				mul_a = prod_q[63:32];
				mul_b = {24'd0, horner_k(h_q)};
			end
			BK_COS: begin
				mul_a = {16'd0, spd_mag};
				mul_b = {16'd0, c_mag};
			end
			BK_OUT:  out_load = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q   <= '0;
			bwd_q     <= 1'b0;
			min_q     <= TTC_INF;
			counter_q <= '0;
		end else begin
			if (state_q == BK_IDLE && !qstat.empty && head.kind == KIND_SPEED) begin
				speed_q <= head.speed;
				bwd_q   <= head.speed[15];
			end
			if (state_q == BK_UPD) begin
				if (last_q) begin
					min_q     <= TTC_INF;
					counter_q <= '0;
				end else begin
					min_q <= min_new;
					if (counter_q < CW'(MAX_SAMPLES - 1)) begin
						counter_q <= counter_q + 1'b1;
					end
				end
			end
		end
	end

	// per-sample datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				range_q <= head.range;
				last_q  <= head.last;
				ttc_q   <= TTC_INF;
			end
			BK_ANG2: a_hi_q <= angle45[44:23];
			BK_PL:   plo_q  <= prod_q[44:0];
			BK_PH:   cneg_q <= fold_neg;
			BK_X2: begin
				x2_q <= prod_q[61:30];
				t_q  <= $signed({1'b0, ONE_Q30});
				h_q  <= '0;
			end
			BK_H2:   n_q  <= prod_q[61:30];
			BK_H3:   qe_q <= prod_q[63:32];
			BK_H4: begin
				t_q <= $signed({1'b0, ONE_Q30}) - $signed(q_fix);
				h_q <= h_q + 1'b1;
			end
			BK_COS:  vneg_q <= speed_q[15] ^ cneg_q;
			BK_V: begin
				v_q    <= v_now;
				r_q    <= {16'd0, range_q[15:1]};
				quo_q  <= '0;
				dcnt_q <= '0;
				if (v_now == '0 || vneg_q) begin
					ttc_q <= TTC_INF;
				end else if (ttc_sat) begin
					ttc_q <= TTC_MAX_FINITE;
				end
			end
			BK_DIV: begin
				r_q    <= div_bit ? 31'(r2 - {1'b0, v_q}) : r2[30:0];
				quo_q  <= quo_next;
				dcnt_q <= dcnt_q + 1'b1;
				if (dcnt_q == 5'd31) begin
					ttc_q <= ttc_div;
				end
			end
			BK_UPD: begin
				res_min_q   <= min_new;
				res_brake_q <= (min_new != '0) && (min_new < thr32);
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_brake_q <= res_brake_q;
			out_min_q   <= res_min_q;
		end
	end

	assign out_ch.valid   = out_valid_q;
	assign out_ch.brake   = out_brake_q;
	assign out_ch.min_ttc = out_min_q;

	`LTB_ASSERT_IMPL(a_horner_pos, state_q == BK_H1, !t_q[32])
	`LTB_ASSERT_IMPL(a_div_rem, state_q == BK_DIV, r_q < v_q)
	`LTB_ASSERT_NEXT(a_scan_clear, state_q == BK_UPD && last_q, min_q == TTC_INF && counter_q == '0)
	`LTB_ASSERT_IMPL(a_out_hold, out_valid_q && !out_ch.ready, !out_load)

endmodule

@@ rtl/lidar_ttc_emergency_brake.sv @@
// top level of the lidar time-to-collision emergency brake
// Speed updates and lidar range samples arrive as beats on in_ch. A speed
// beat only updates the stored speed. A sample outside [range_lo, range_hi]
// skips the datapath and goes straight to the scan update; a valid sample
// passes through angle, quadrant fold and a six-step Horner cosine on one
// shared 32x32 registered multiplier, a closing-rate product, and a
// bit-serial restoring divider for the ttc. While the back end works, the
// front end keeps accepting beats into a two-entry queue until it is full, and a
// finished result sits in an output register so a stalled sink does not block
// the queue until the next last sample. The last sample of a scan produces one
// result beat on out_ch with the scan minimum ttc (Q16.16, all ones for
// infinite) and brake, set when 0 < min < threshold; threshold follows the
// sign of the latest speed. Configuration writes on cfg_we take effect at
// once and should only be made while no beat is in flight.
module lidar_ttc_emergency_brake import ltb_pkg::*; #(
	parameter int MAX_SAMPLES    = MAX_SAMPLES_DEF,
	parameter int COS_TABLE_BITS = COS_TABLE_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	ltb_in_if.sink    in_ch,
	ltb_out_if.source out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t   cfg_q;
	qstat_t qstat;
	qent_t  push_ent, head;
	logic   push, pop;

	// configuration registers, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_fwd     <= THR_FWD_RST;
			cfg_q.thr_bwd     <= THR_BWD_RST;
			cfg_q.range_lo    <= RANGE_LO_RST;
			cfg_q.range_hi    <= RANGE_HI_RST;
			cfg_q.angle_start <= ANGLE_START_RST;
			cfg_q.angle_step  <= ANGLE_STEP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR_FWD:     cfg_q.thr_fwd     <= cfg_data;
				REG_THR_BWD:     cfg_q.thr_bwd     <= cfg_data;
				REG_RANGE_LO:    cfg_q.range_lo    <= cfg_data;
				REG_RANGE_HI:    cfg_q.range_hi    <= cfg_data;
				REG_ANGLE_START: cfg_q.angle_start <= cfg_data;
				REG_ANGLE_STEP:  cfg_q.angle_step  <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// front end: handshake and range classification
	ltb_front u_front (
		.in_ch    (in_ch),
		.cfg      (cfg_q),
		.qstat    (qstat),
		.push     (push),
		.push_ent (push_ent)
	);

	// decoupling queue
	ltb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.qstat    (qstat),
		.head     (head)
	);

	// back end: ttc sequencer, scan minimum, result register
	ltb_back #(
		.MAX_SAMPLES    (MAX_SAMPLES),
		.COS_TABLE_BITS (COS_TABLE_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule
